// ----- rtl/core/slwa_pkg.sv -----
`default_nettype none

package slwa_pkg;

  localparam int FULL_TURN = 4096;
  localparam logic signed [31:0] TURN_S = 32'(FULL_TURN);
  localparam logic signed [31:0] HALF_TURN = 32'(FULL_TURN / 2);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  localparam int QUO_W = 32;
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = QUO_W / DIV_STEP;
  localparam int DIVISOR_W = 15;

  typedef enum logic {
    OP_LINEAR  = 1'b0,
    OP_HEADING = 1'b1
  } op_t;

  typedef struct packed {
    logic                 heading;
    logic [31:0]          start_v;
    logic [31:0]          end_v;
    logic [31:0]          pos;
    logic [DIVISOR_W-1:0] divisor;
  } item_t;

  typedef struct packed {
    logic                 neg;
    logic                 heading;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIVISOR_W-1:0] rem;
    logic [QUO_W-1:0]     quo;
  } div_t;

  // restoring division, DIV_STEP quotient bits per call
  function automatic div_t div_step(div_t d);
    logic [DIVISOR_W:0] r;
    div_t               o;
    o = d;
    for (int k = 0; k < DIV_STEP; k++) begin
      r = {o.rem, o.quo[QUO_W-1]};
      o.quo = {o.quo[QUO_W-2:0], 1'b0};
      if (r >= {1'b0, o.divisor}) begin
        o.rem    = DIVISOR_W'(r - {1'b0, o.divisor});
        o.quo[0] = 1'b1;
      end else begin
        o.rem = r[DIVISOR_W-1:0];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/slwa_front.sv -----
`default_nettype none

module slwa_front
  import slwa_pkg::*;
(
  input  wire logic               opcode,
  input  wire logic signed [31:0] start_value,
  input  wire logic signed [31:0] end_value,
  input  wire logic signed [31:0] position,
  input  wire logic signed [15:0] span,
  output item_t                   item
);

  logic               heading;
  logic               bypass;
  logic signed [31:0] s16;
  logic signed [31:0] e16;
  logic signed [31:0] diff;
  logic signed [31:0] s_sel;
  logic signed [31:0] e_sel;

  assign heading = (op_t'(opcode) == OP_HEADING);
  assign bypass  = span[15] || (span == 16'sd0);
  assign s16     = 32'(signed'(start_value[15:0]));
  assign e16     = 32'(signed'(end_value[15:0]));
  assign diff    = e16 - s16;

  always_comb begin
    s_sel = start_value;
    e_sel = end_value;
    if (heading) begin
      s_sel = s16;
      e_sel = e16;
      if (diff > HALF_TURN) begin
        e_sel = e16 - TURN_S;
      end else if (diff < -HALF_TURN) begin
        s_sel = s16 - TURN_S;
      end
    end
    item.heading = heading;
    if (bypass) begin
      // start*1 + start*0, over 1
      item.start_v = heading ? s16 : start_value;
      item.end_v   = item.start_v;
      item.pos     = 32'd1;
      item.divisor = DIVISOR_W'(1);
    end else begin
      item.start_v = s_sel;
      item.end_v   = e_sel;
      item.pos     = position;
      item.divisor = span[DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slwa_queue.sv -----
`default_nettype none

module slwa_queue
  import slwa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      rd_item,
  output logic       empty
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slwa_back.sv -----
`default_nettype none

module slwa_back
  import slwa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_result
);

  logic                 en;

  // multiply stage
  logic                 m_vld_r;
  logic [31:0]          m_pe_r;
  logic [31:0]          m_ps_r;
  logic [DIVISOR_W-1:0] m_div_r;
  logic                 m_head_r;
  logic [31:0]          rem_w;
  logic [31:0]          pe_w;
  logic [31:0]          ps_w;

  // sum / magnitude stage
  logic                 a_vld_r;
  div_t                 a_r;
  logic [31:0]          sum_w;

  // divider stages
  logic                 d_vld_r [DIV_STAGES];
  div_t                 d_r     [DIV_STAGES];

  // result buffer
  logic [31:0]          ob_r [ODEPTH];
  logic [OPTR_W-1:0]    ob_wr_r, ob_wr_nxt;
  logic [OPTR_W-1:0]    ob_rd_r, ob_rd_nxt;
  logic [OCNT_W-1:0]    ob_cnt_r, ob_cnt_nxt;
  logic                 ob_push;
  logic                 ob_pop;
  logic [QUO_W-1:0]     q_signed;
  logic [31:0]          res_w;
  div_t                 last;

  assign en    = (ob_cnt_r != OCNT_W'(ODEPTH));
  assign q_pop = en && !q_empty;

  assign rem_w = {{(32-DIVISOR_W){1'b0}}, q_item.divisor} - q_item.pos;
  assign pe_w  = q_item.end_v * q_item.pos;
  assign ps_w  = q_item.start_v * rem_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pe_r   <= pe_w;
      m_ps_r   <= ps_w;
      m_div_r  <= q_item.divisor;
      m_head_r <= q_item.heading;
    end
  end

  assign sum_w = m_pe_r + m_ps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.neg     <= sum_w[31];
      a_r.heading <= m_head_r;
      a_r.divisor <= m_div_r;
      a_r.rem     <= '0;
      a_r.quo     <= sum_w[31] ? (~sum_w + 32'd1) : sum_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        d_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      d_vld_r[0] <= a_vld_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        d_vld_r[i] <= d_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= div_step(a_r);
      for (int i = 1; i < DIV_STAGES; i++) begin
        d_r[i] <= div_step(d_r[i-1]);
      end
    end
  end

  // sign restore, heading wraps to 16 bits
  assign last     = d_r[DIV_STAGES-1];
  assign q_signed = last.neg ? (~last.quo + 32'd1) : last.quo;
  assign res_w    = last.heading ? 32'(signed'(q_signed[15:0])) : q_signed;

  assign ob_push    = en && d_vld_r[DIV_STAGES-1];
  assign out_empty  = (ob_cnt_r == '0);
  assign ob_pop     = out_pop && !out_empty;
  assign out_result = ob_r[ob_rd_r];

  always_comb begin
    ob_wr_nxt  = ob_push ? ob_wr_r + 1'b1 : ob_wr_r;
    ob_rd_nxt  = ob_pop ? ob_rd_r + 1'b1 : ob_rd_r;
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 1'b1;
    end else if (ob_pop && !ob_push) begin
      ob_cnt_nxt = ob_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      ob_wr_r  <= ob_wr_nxt;
      ob_rd_r  <= ob_rd_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_r[ob_wr_r] <= res_w;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/segment_lerp_with_angle_wrap_unit.sv -----
// Throughput: one transaction per cycle while the result buffer has room;
// 32-bit quotient from 8 divider stages, 4 bits each, behind one multiply
// stage and one sum/sign stage.
// Reset: synchronous, active low; clears the input queue, pipeline valids and
// result buffer. Payload registers are not reset.
`default_nettype none

module segment_lerp_with_angle_wrap_unit
  import slwa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_opcode,
  input  wire logic signed [31:0] in_start_value,
  input  wire logic signed [31:0] in_end_value,
  input  wire logic signed [31:0] in_position,
  input  wire logic signed [15:0] in_span,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [31:0]      out_result
);

  item_t       f_item;
  item_t       q_item;
  logic        q_empty;
  logic        q_pop;
  logic [31:0] res;

  slwa_front u_front (
    .opcode      (in_opcode),
    .start_value (in_start_value),
    .end_value   (in_end_value),
    .position    (in_position),
    .span        (in_span),
    .item        (f_item)
  );

  slwa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (f_item),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  slwa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (res)
  );

  assign out_result = signed'(res);

endmodule

`default_nettype wire

// ----- rtl/core/slwa_checker.sv -----
`default_nettype none

module slwa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic signed [31:0] out_result
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("input full without a transaction");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_result))
    else $error("waiting result changed");

endmodule

bind segment_lerp_with_angle_wrap_unit slwa_checker u_chk (.*);

`default_nettype wire
